// File: hdl/wdfc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the WLAN descrambler and FCS check.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package wdfc_pkg;

   localparam int unsigned LenWidth   = 12;
   localparam int unsigned SeedBits   = 7;
   localparam int unsigned ServBits   = 16;
   localparam int unsigned HdrWidth   = 5;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
   localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

   localparam logic [LenWidth-1:0] LenReset   = 12'd4;
   localparam logic [31:0]         CrcInit    = 32'hFFFF_FFFF;
   localparam logic [31:0]         CrcPoly    = 32'hEDB8_8320;
   localparam logic [31:0]         CrcResidue = 32'd558161692;

   // One assembled PSDU byte on its way from the front to the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       first_byte;
   } byte_item_type;

   // Push side of the byte queue.
   typedef struct packed {
      logic          valid;
      byte_item_type item;
   } q_push_type;

   // Pop side of the byte queue.
   typedef struct packed {
      logic          valid;
      byte_item_type item;
   } q_head_type;

   // Reflected CRC-32 update over one byte, least significant bit first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/wdfc_front.sv
// Front end: accepts scrambled bits, runs the descrambler and packs PSDU bytes.
// Depends on wdfc_pkg; pushes finished bytes into wdfc_queue.
`timescale 1ns / 1ps

module wdfc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_coded_bit,
   input  logic                          req_frame_start,
   input  logic [wdfc_pkg::LenWidth-1:0] psdu_length,
   input  logic                          q_full,
   output wdfc_pkg::q_push_type          q_push
);
   import wdfc_pkg::*;

   logic                active_ff, active_in;
   logic [HdrWidth-1:0] hdr_ff, hdr_in;
   logic [6:0]          scr_ff, scr_in;
   logic [2:0]          bitcnt_ff, bitcnt_in;
   logic [LenWidth-1:0] bytecnt_ff, bytecnt_in;
   logic [7:0]          shift_ff, shift_in;

   logic                accept;
   logic                active;
   logic [HdrWidth-1:0] hdr;
   logic [6:0]          scr;
   logic [2:0]          bitcnt;
   logic [LenWidth-1:0] bytecnt;
   logic                fb;
   logic                dbit;
   logic [LenWidth:0]   byte_index;
   logic                last;

   // A bit is taken whenever the queue has room for a possible byte.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Frame start restarts the counters for this very bit.
   always_comb begin
      active  = req_frame_start || active_ff;
      hdr     = req_frame_start ? '0 : hdr_ff;
      scr     = req_frame_start ? '0 : scr_ff;
      bitcnt  = req_frame_start ? '0 : bitcnt_ff;
      bytecnt = req_frame_start ? '0 : bytecnt_ff;
      fb      = scr[6] ^ scr[3];
      dbit    = fb ^ req_coded_bit;
      byte_index = {1'b0, bytecnt} + 1'b1;
      last    = byte_index >= {1'b0, psdu_length};
   end

   // Next state of the descrambler, header counter and byte packer.
   always_comb begin
      active_in  = active_ff;
      hdr_in     = hdr_ff;
      scr_in     = scr_ff;
      bitcnt_in  = bitcnt_ff;
      bytecnt_in = bytecnt_ff;
      shift_in   = shift_ff;
      q_push     = '0;
      if (accept && active) begin
         active_in  = 1'b1;
         hdr_in     = hdr;
         scr_in     = scr;
         bitcnt_in  = bitcnt;
         bytecnt_in = bytecnt;
         shift_in   = shift_ff;
         if (hdr < HdrWidth'(SeedBits)) begin
            // Seed bits load the LFSR, first bit in the top position.
            scr_in[3'(6) - hdr[2:0]] = req_coded_bit;
            hdr_in = hdr + 1'b1;
         end else begin
            scr_in = {scr[5:0], fb};
            if (hdr < HdrWidth'(ServBits)) begin
               hdr_in = hdr + 1'b1;
               if (hdr_in == HdrWidth'(ServBits) && psdu_length == '0) begin
                  active_in = 1'b0;
               end
            end else begin
               shift_in  = {dbit, shift_ff[7:1]};
               bitcnt_in = bitcnt + 1'b1;
               if (bitcnt == 3'd7) begin
                  q_push.valid           = 1'b1;
                  q_push.item.data_byte  = shift_in;
                  q_push.item.last_byte  = last;
                  q_push.item.first_byte = (bytecnt == '0);
                  bytecnt_in             = byte_index[LenWidth-1:0];
                  if (last) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Control state is reset; the byte shift register is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         hdr_ff     <= '0;
         scr_ff     <= '0;
         bitcnt_ff  <= '0;
         bytecnt_ff <= '0;
      end else begin
         active_ff  <= active_in;
         hdr_ff     <= hdr_in;
         scr_ff     <= scr_in;
         bitcnt_ff  <= bitcnt_in;
         bytecnt_ff <= bytecnt_in;
      end
      shift_ff <= shift_in;
   end

endmodule

// File: hdl/wdfc_queue.sv
// Short register queue of assembled bytes between the front and the back.
// Depends on wdfc_pkg for the item type and depth.
`timescale 1ns / 1ps

module wdfc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  wdfc_pkg::q_push_type q_push,
   output logic                 q_full,
   input  logic                 q_pop,
   output wdfc_pkg::q_head_type q_head
);
   import wdfc_pkg::*;

   byte_item_type        mem_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ff, wr_in;
   logic [QPtrWidth-1:0] rd_ff, rd_in;
   logic [QCntWidth-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign q_full       = (cnt_ff == QCntWidth'(QueueDepth));
   assign q_head.valid = (cnt_ff != '0);
   assign q_head.item  = mem_ff[rd_ff];
   assign do_push      = q_push.valid;
   assign do_pop       = q_pop && q_head.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCntWidth'(do_push) - QCntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage write; entries are payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= q_push.item;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntWidth'(QueueDepth))
      else $error("byte queue occupancy beyond its depth");

   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> !q_full)
      else $error("byte pushed into a full queue");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      (q_push.valid && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("byte queue count did not follow a push");

endmodule

// File: hdl/wdfc_back.sv
// Back end: runs the CRC-32 over queued bytes and holds the result beat.
// Depends on wdfc_pkg for the CRC function and constants.
`timescale 1ns / 1ps

module wdfc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  wdfc_pkg::q_head_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_last_byte,
   output logic                 rsp_crc_good
);
   import wdfc_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic        good_ff;
   logic [31:0] crc_base;
   logic        good_in;

   // Take a byte when the output register is empty or being drained.
   assign q_pop = q_head.valid && (!valid_ff || rsp_ready);

   // CRC restarts on the first byte of each frame.
   always_comb begin
      crc_base = q_head.item.first_byte ? CrcInit : crc_ff;
      crc_in   = q_pop ? crc_byte(crc_base, q_head.item.data_byte) : crc_ff;
      good_in  = q_head.item.last_byte && ((crc_in ^ CrcInit) == CrcResidue);
      valid_in = q_pop || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff   <= CrcInit;
      end else begin
         valid_ff <= valid_in;
         crc_ff   <= crc_in;
      end
      if (q_pop) begin
         data_ff <= q_head.item.data_byte;
         last_ff <= q_head.item.last_byte;
         good_ff <= good_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_last_byte = last_ff;
   assign rsp_crc_good  = good_ff;

   a_good_only_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_crc_good) |-> rsp_last_byte)
      else $error("crc_good raised on a byte that is not the last");

   a_hold_when_stalled : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_byte)))
      else $error("result beat changed while stalled");

endmodule

// File: hdl/wlan_descrambler_fcs_check.sv
// Top level of the WLAN descrambler with CRC-32 frame check.
// Depends on wdfc_pkg, wdfc_front, wdfc_queue and wdfc_back.
//
//   Channel  Direction  Beat                          Handshake
//   req_     in         one scrambled bit + start     req_valid / req_ready
//   rsp_     out        PSDU byte + last, crc_good    rsp_valid / rsp_ready
//   csr_     in         psdu_length (12 bits)         csr_valid / csr_ready
//
// One bit is accepted per cycle while the byte queue is not full; a byte leaves the front every eighth payload bit.
// A byte passes through the four-entry byte queue and then the output register of the back before it reaches rsp_.
// req_ready drops only while the byte queue is full, i.e. rsp_ has stalled for long.
// Reset is synchronous and clears the frame state; psdu_length returns to 4.
// csr_ready is always high; the length is sampled by the front on every bit.
`timescale 1ns / 1ps

module wlan_descrambler_fcs_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_coded_bit,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_last_byte,
   output logic                          rsp_crc_good,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wdfc_pkg::LenWidth-1:0] csr_psdu_length
);
   import wdfc_pkg::*;

   logic [LenWidth-1:0] len_ff, len_in;
   q_push_type          q_push;
   q_head_type          q_head;
   logic                q_full;
   logic                q_pop;

   // Length register write.
   assign csr_ready = 1'b1;
   assign len_in    = (csr_valid && csr_ready) ? csr_psdu_length : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LenReset;
      end else begin
         len_ff <= len_in;
      end
   end

   wdfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coded_bit   (req_coded_bit),
      .req_frame_start (req_frame_start),
      .psdu_length     (len_ff),
      .q_full          (q_full),
      .q_push          (q_push)
   );

   wdfc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   wdfc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last_byte (rsp_last_byte),
      .rsp_crc_good  (rsp_crc_good)
   );

endmodule
